@@ rtl/core/tfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tfl_pkg;

  localparam int FRAC_BITS = 16;
  // every quotient in this block stays below 4.0
  localparam int DIV_EXTRA = 2;
  localparam int QUO_W = FRAC_BITS + DIV_EXTRA;
  localparam int DIV_W = 64;
  localparam int HALF_W = 31;
  localparam int KIND_W = 4;
  // input register, square, operand build, divider, min select, product, output
  localparam int PIPE_LAT = QUO_W + 6;

  localparam logic [KIND_W-1:0] KIND_SUPERBEE = 4'd0;
  localparam logic [KIND_W-1:0] KIND_MINMOD = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MC = 4'd2;
  localparam logic [KIND_W-1:0] KIND_VANLEER = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ALBADA = 4'd4;
  localparam logic [KIND_W-1:0] KIND_BARTH = 4'd5;
  localparam logic [KIND_W-1:0] KIND_VENKAT = 4'd6;
  localparam logic [KIND_W-1:0] KIND_UPWIND = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SOU = 4'd8;
  localparam logic [KIND_W-1:0] KIND_QUICK = 4'd9;
  localparam logic [KIND_W-1:0] KIND_KOREN = 4'd10;

  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_Q = 64'sd2 <<< FRAC_BITS;
  localparam logic signed [63:0] THREE_Q = 64'sd3 <<< FRAC_BITS;
  localparam logic signed [63:0] FOUR_Q = 64'sd4 <<< FRAC_BITS;
  localparam logic signed [63:0] SIX_Q = 64'sd6 <<< FRAC_BITS;
  localparam logic signed [63:0] ELEVEN_Q = 64'sd11 <<< FRAC_BITS;
  localparam logic signed [63:0] TWELVE_Q = 64'sd12 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic zero;
    logic [HALF_W-1:0] half;
    logic signed [63:0] base;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_op_t;

  function automatic logic signed [63:0] smin(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic signed [63:0] smax(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    return (x > y) ? x : y;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tvd_flux_limiter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                 payload
// request   in         start & !busy             slope_ratio (Q16.16)
// result    out        done, one cycle           limiter_value, saturated
// config    in/out     APB, pready tied high     limiter_kind at 0x0
//
// One request per clock. The divider is the longest part of the pipe, with
// one quotient bit per stage; slope_ratio and limiter_value are Q16.16.
// Reset is synchronous; busy is high only while rst is high, and the pipe
// is flushed. Results cannot be held off, so the pipe never stalls.
module tvd_flux_limiter_unit import tfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] slope_ratio,
  output logic done,
  output logic signed [31:0] limiter_value,
  output logic saturated,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam logic REG_KIND = 1'b0;

  logic [KIND_W-1:0] kind_reg;
  logic accept, cfg_wr;
  logic prep_vld, div_vld;
  side_t prep_side, div_side;
  div_op_t op_a, op_b;
  logic [QUO_W-1:0] quo_a, quo_b;

  assign busy = rst;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_KIND) ? {28'd0, kind_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_reg <= KIND_SUPERBEE;
    end else if (cfg_wr && (paddr[2] == REG_KIND)) begin
      kind_reg <= pwdata[KIND_W-1:0];
    end
  end

  // input reg, r*r, divider operand build
  tfl_prep u_prep (
    .clk(clk), .rst(rst), .in_vld(accept), .in_r(slope_ratio), .in_kind(kind_reg),
    .out_vld(prep_vld), .out_side(prep_side), .out_op_a(op_a), .out_op_b(op_b)
  );

  // main quotient; sideband rides along here
  tfl_div u_div_a (
    .clk(clk), .rst(rst), .in_vld(prep_vld), .in_op(op_a), .in_side(prep_side),
    .out_vld(div_vld), .out_quo(quo_a), .out_side(div_side)
  );

  // second quotient for Barth and Venkatakrishnan
  tfl_div u_div_b (
    .clk(clk), .rst(rst), .in_vld(prep_vld), .in_op(op_b), .in_side(prep_side),
    .out_vld(), .out_quo(quo_b), .out_side()
  );

  // min select, (1+r)/2 product, clamp
  tfl_post u_post (
    .clk(clk), .rst(rst), .in_vld(div_vld), .quo_a(quo_a), .quo_b(quo_b),
    .in_side(div_side), .done(done), .limiter_value(limiter_value),
    .saturated(saturated)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("result strobe missing after fixed latency");

  a_upwind_zero: assert property (@(posedge clk) disable iff (rst)
    accept && ((kind_reg == KIND_UPWIND) || (kind_reg > KIND_KOREN))
      |-> ##PIPE_LAT (limiter_value == 32'sd0 && !saturated))
    else $error("upwind or unused kind gave nonzero result");

  a_sou_pass: assert property (@(posedge clk) disable iff (rst)
    accept && (kind_reg == KIND_SOU)
      |-> ##PIPE_LAT (limiter_value == $past(slope_ratio, PIPE_LAT)))
    else $error("second-order upwind did not pass r through");

endmodule
`default_nettype wire

@@ rtl/core/tfl_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfl_prep import tfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  logic signed [31:0] in_r,
  input  logic [KIND_W-1:0] in_kind,
  output logic out_vld,
  output side_t out_side,
  output div_op_t out_op_a,
  output div_op_t out_op_b
);

  logic v1, v2;
  logic signed [31:0] r1, r2;
  logic [KIND_W-1:0] k1, k2;
  logic [HALF_W-1:0] mag1;
  logic [61:0] sq2;

  logic signed [63:0] rr, absr, two_r, sf, ss, t, h, a, b, base, hh;
  logic signed [63:0] num_a, den_a, num_b, den_b;
  logic pos, zero;
  side_t side_next;
  div_op_t op_a_next, op_b_next;

  assign mag1 = r1[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
    r1 <= in_r;
    k1 <= in_kind;
    r2 <= r1;
    k2 <= k1;
    sq2 <= mag1 * mag1;
    out_side <= side_next;
    out_op_a <= op_a_next;
    out_op_b <= op_b_next;
  end

  always_comb begin
    rr = {{32{r2[31]}}, r2};
    pos = !r2[31] && (r2 != 32'sd0);
    absr = r2[31] ? -rr : rr;
    two_r = rr <<< 1;
    sf = {2'b00, sq2};
    ss = sf >>> FRAC_BITS;
    base = '0;
    num_a = '0;
    den_a = ONE_Q;
    num_b = '0;
    den_b = ONE_Q;
    t = '0;
    h = '0;
    a = '0;
    b = '0;
    case (k2)
      KIND_SUPERBEE: begin
        a = smin(two_r, ONE_Q);
        b = smin(rr, TWO_Q);
        base = smax(64'sd0, smax(a, b));
      end
      KIND_MINMOD: base = smax(64'sd0, smin(rr, ONE_Q));
      KIND_MC: begin
        t = ONE_Q + rr;
        h = (t + {63'd0, t[63]}) >>> 1;
        a = smin(smin(two_r, h), TWO_Q);
        base = smax(64'sd0, a);
      end
      KIND_VANLEER: begin
        num_a = rr + absr;
        den_a = ONE_Q + absr;
      end
      KIND_ALBADA: begin
        num_a = sf + (rr <<< FRAC_BITS);
        den_a = sf + ONE_SQ;
      end
      KIND_BARTH: begin
        num_a = rr <<< 2;
        den_a = ONE_Q + rr;
        num_b = FOUR_Q;
        den_b = ONE_Q + rr;
      end
      KIND_VENKAT: begin
        num_a = (ss <<< 3) + (ss <<< 2) + (rr <<< 2);
        den_a = (ss <<< 3) + (ss <<< 1) + ss + (rr <<< 2) + ONE_Q;
        num_b = (rr <<< 2) + TWELVE_Q;
        den_b = ss + (rr <<< 2) + ELEVEN_Q;
      end
      KIND_SOU: base = rr;
      KIND_QUICK: begin
        t = THREE_Q + rr;
        base = (t + (t[63] ? 64'sd3 : 64'sd0)) >>> 2;
      end
      KIND_KOREN: begin
        // n/3 with n clipped at 6.0: a clipped quotient still ends at 2.0
        t = ONE_Q + two_r;
        num_a = smax(64'sd0, smin(t, SIX_Q));
        den_a = THREE_Q;
        base = smin(two_r, TWO_Q);
      end
      default: base = '0;
    endcase
    zero = ((k2 == KIND_ALBADA) || (k2 == KIND_BARTH) || (k2 == KIND_VENKAT)) && !pos;
    if (zero) begin
      num_a = '0;
      den_a = ONE_Q;
      num_b = '0;
      den_b = ONE_Q;
    end
    hh = (ONE_Q + rr) >>> 1;
    side_next.kind = k2;
    side_next.zero = zero;
    side_next.half = hh[HALF_W-1:0];
    side_next.base = base;
    op_a_next.num = num_a;
    op_a_next.den = den_a;
    op_b_next.num = num_b;
    op_b_next.den = den_b;
  end

endmodule
`default_nettype wire

@@ rtl/core/tfl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfl_div import tfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  div_op_t in_op,
  input  side_t in_side,
  output logic out_vld,
  output logic [QUO_W-1:0] out_quo,
  output side_t out_side
);

  // one quotient bit per stage, restoring
  logic vld_q [QUO_W];
  logic [DIV_W-1:0] p_q [QUO_W];
  logic [DIV_W-1:0] d_q [QUO_W];
  logic [DIV_EXTRA-1:0] lo_q [QUO_W];
  logic [QUO_W-1:0] q_q [QUO_W];
  side_t s_q [QUO_W];

  logic vld_i [QUO_W];
  logic [DIV_W-1:0] p_i [QUO_W];
  logic [DIV_W-1:0] d_i [QUO_W];
  logic [DIV_EXTRA-1:0] lo_i [QUO_W];
  logic [QUO_W-1:0] q_i [QUO_W];
  side_t s_i [QUO_W];

  logic [DIV_W:0] t_w [QUO_W];
  logic [DIV_W:0] diff_w [QUO_W];
  logic ge_w [QUO_W];
  logic [DIV_W-1:0] p_n [QUO_W];
  logic [DIV_EXTRA-1:0] lo_n [QUO_W];
  logic [QUO_W-1:0] q_n [QUO_W];

  always_comb begin
    vld_i[0] = in_vld;
    p_i[0] = in_op.num >> DIV_EXTRA;
    d_i[0] = in_op.den;
    lo_i[0] = in_op.num[DIV_EXTRA-1:0];
    q_i[0] = '0;
    s_i[0] = in_side;
    for (int j = 1; j < QUO_W; j++) begin
      vld_i[j] = vld_q[j-1];
      p_i[j] = p_q[j-1];
      d_i[j] = d_q[j-1];
      lo_i[j] = lo_q[j-1];
      q_i[j] = q_q[j-1];
      s_i[j] = s_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) begin
      t_w[j] = {p_i[j], lo_i[j][DIV_EXTRA-1]};
      diff_w[j] = t_w[j] - {1'b0, d_i[j]};
      ge_w[j] = t_w[j] >= {1'b0, d_i[j]};
      p_n[j] = ge_w[j] ? diff_w[j][DIV_W-1:0] : t_w[j][DIV_W-1:0];
      lo_n[j] = lo_i[j] << 1;
      q_n[j] = {q_i[j][QUO_W-2:0], ge_w[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUO_W; j++) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_i[j];
      end
      p_q[j] <= p_n[j];
      d_q[j] <= d_i[j];
      lo_q[j] <= lo_n[j];
      q_q[j] <= q_n[j];
      s_q[j] <= s_i[j];
    end
  end

  assign out_vld = vld_q[QUO_W-1];
  assign out_quo = q_q[QUO_W-1];
  assign out_side = s_q[QUO_W-1];

endmodule
`default_nettype wire

@@ rtl/core/tfl_post.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfl_post import tfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  logic [QUO_W-1:0] quo_a,
  input  logic [QUO_W-1:0] quo_b,
  input  side_t in_side,
  output logic done,
  output logic signed [31:0] limiter_value,
  output logic saturated
);

  logic v4, v5;
  logic signed [63:0] m4, m_next, qa64, qb64, val5, val_next;
  logic [KIND_W-1:0] kind4;
  logic zero4;
  logic [HALF_W-1:0] half4;
  logic [HALF_W+QUO_W-1:0] prod;

  always_comb begin
    qa64 = {{(64-QUO_W){1'b0}}, quo_a};
    qb64 = {{(64-QUO_W){1'b0}}, quo_b};
    case (in_side.kind) inside
      KIND_VANLEER, KIND_ALBADA: m_next = qa64;
      KIND_BARTH: m_next = smin(ONE_Q, smin(qa64, qb64));
      KIND_VENKAT: m_next = smin(qa64, qb64);
      KIND_KOREN: m_next = smax(64'sd0, smin(in_side.base, qa64));
      default: m_next = in_side.base;
    endcase
  end

  always_comb begin
    prod = half4 * m4[QUO_W-1:0];
    if (zero4) begin
      val_next = '0;
    end else if ((kind4 == KIND_BARTH) || (kind4 == KIND_VENKAT)) begin
      val_next = 64'(prod >> FRAC_BITS);
    end else begin
      val_next = m4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v4 <= in_vld;
      v5 <= v4;
      done <= v5;
    end
    m4 <= m_next;
    kind4 <= in_side.kind;
    zero4 <= in_side.zero;
    half4 <= in_side.half;
    val5 <= val_next;
    if (val5 > Q_MAX) begin
      limiter_value <= 32'sh7fffffff;
      saturated <= 1'b1;
    end else if (val5 < Q_MIN) begin
      limiter_value <= 32'sh80000000;
      saturated <= 1'b1;
    end else begin
      limiter_value <= val5[31:0];
      saturated <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ sim/tvd_flux_limiter_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the TVD flux limiter: each slope ratio request is
// predicted in Q16.16 by a local model of all eleven limiters; every done
// strobe is checked against the oldest prediction.
module tvd_flux_limiter_unit_test;
  import tfl_pkg::*;

  localparam int LAT = PIPE_LAT + 4;
  localparam logic [2:0] ADDR_KIND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd11;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  typedef struct {
    logic signed [31:0] value;
    logic sat;
  } phi_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] slope_ratio;
  logic done;
  logic signed [31:0] limiter_value;
  logic saturated;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // bench copy of the limiter select register
  logic [KIND_W-1:0] cur_kind;
  // predicted results, oldest first
  phi_t phi_queue[$];
  int errors;
  bit allow_gaps;

  tvd_flux_limiter_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .slope_ratio(slope_ratio), .done(done), .limiter_value(limiter_value),
    .saturated(saturated), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor(n * 2^16 / d), capped like a divider that overflows
  function automatic longint fixed_quot(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    if (d == 0) return 0;
    q = n / d;
    rem = n % d;
    if ((q >> (62 - FRAC_BITS)) != 0) return longint'(64'd1 << 62);
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  function automatic longint lmin(input longint a, input longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(input longint a, input longint b);
    return a > b ? a : b;
  endfunction

  function automatic phi_t predict_phi(input logic [KIND_W-1:0] kind,
                                       input logic signed [31:0] ratio);
    longint r, one, a, b, m, v;
    logic [63:0] s, n, d;
    phi_t res;
    r = longint'(ratio);
    one = longint'(ONE_Q);
    v = 0;
    case (kind)
      KIND_SUPERBEE: v = lmax(0, lmax(lmin(2 * r, one), lmin(r, 2 * one)));
      KIND_MINMOD: v = lmax(0, lmin(r, one));
      KIND_MC: v = lmax(0, lmin(lmin(2 * r, (one + r) / 2), 2 * one));
      KIND_VANLEER: begin
        a = r < 0 ? -r : r;
        v = fixed_quot(r + a, one + a);
      end
      KIND_ALBADA: if (r > 0) begin
        s = r * r;
        n = s + r * one;
        d = s + one * one;
        v = fixed_quot(n, d);
      end
      KIND_BARTH: if (r > 0) begin
        a = fixed_quot(4 * r, one + r);
        b = fixed_quot(4 * one, one + r);
        m = lmin(one, lmin(a, b));
        v = longint'((64'((one + r) / 2) * 64'(m)) >> FRAC_BITS);
      end
      KIND_VENKAT: if (r > 0) begin
        s = 64'(r * r) >> FRAC_BITS;
        n = 12 * s + 4 * r;
        d = 11 * s + 4 * r + one;
        a = fixed_quot(n, d);
        n = 4 * (r + 3 * one);
        d = s + 4 * r + 11 * one;
        b = fixed_quot(n, d);
        m = lmin(a, b);
        v = longint'((64'((one + r) / 2) * 64'(m)) >> FRAC_BITS);
      end
      KIND_SOU: v = r;
      KIND_QUICK: v = (3 * one + r) / 4;
      KIND_KOREN: v = lmax(0, lmin(lmin(2 * r, (one + 2 * r) / 3), 2 * one));
      default: v = 0;
    endcase
    res.sat = 1'b0;
    if (v > longint'(Q_MAX)) begin
      v = Q_MAX;
      res.sat = 1'b1;
    end else if (v < longint'(Q_MIN)) begin
      v = Q_MIN;
      res.sat = 1'b1;
    end
    res.value = v[31:0];
    return res;
  endfunction

  // result checker: done cannot be held off, so every strobe is a result
  always @(posedge clk) begin
    phi_t exp_phi;
    if (!rst && done) begin
      if (phi_queue.size() == 0) begin
        $display("%0t: unexpected result value=%h sat=%b", $time, limiter_value,
                 saturated);
        errors++;
      end else begin
        exp_phi = phi_queue.pop_front();
        if (limiter_value !== exp_phi.value) begin
          $display("%0t: limiter_value expected %h actual %h", $time, exp_phi.value,
                   limiter_value);
          errors++;
        end
        if (saturated !== exp_phi.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_phi.sat,
                   saturated);
          errors++;
        end
      end
    end
  end

  // start drops only while the sender idles
  task automatic idle_burst();
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // one request; prediction uses the kind in force when it is accepted
  task automatic send_ratio(input logic signed [31:0] ratio);
    idle_burst();
    start <= 1'b1;
    slope_ratio <= ratio;
    @(posedge clk);
    while (busy) @(posedge clk);
    phi_queue.push_back(predict_phi(cur_kind, ratio));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (phi_queue.size() != 0 && guard < 100 * LAT) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_kind(input logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_KIND;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_kind = value[KIND_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small ratios near the limiter knees, some full-range values
  function automatic logic signed [31:0] rand_ratio();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0002_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0001_0000;
    endcase
  endfunction

  // extremes and knees of every limiter
  task automatic test_directed();
    logic signed [31:0] corners[] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1,
      32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000,
      32'sh0000_5555, 32'sh0003_0000, 32'sh0004_0000, 32'sh0000_0100,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_FFFF};
    for (int k = 0; k <= KIND_UNUSED_HI; k++) begin
      write_kind(k);
      foreach (corners[i]) send_ratio(corners[i]);
    end
  endtask

  // random ratios across every limiter kind, unused kinds 11 and 12 included
  task automatic test_random(input int count, input bit gaps);
    allow_gaps = gaps;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) write_kind($urandom_range(0, KIND_UNUSED_LO + 1));
      send_ratio(rand_ratio());
    end
  endtask

  // requests, gaps while allow_gaps is set, wait for empty pipe, then unused kind and superbee
  task automatic test_wait_empty();
    write_kind(KIND_VENKAT);
    repeat (40) send_ratio(rand_ratio());
    drain();
    write_kind(KIND_UNUSED_HI);
    repeat (10) send_ratio(rand_ratio());
    write_kind(KIND_SUPERBEE);
    repeat (10) send_ratio(rand_ratio());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    slope_ratio = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    allow_gaps = 1'b1;
    cur_kind = KIND_SUPERBEE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_ratio(32'sh0001_8000);  // reset kind is superbee
    test_directed();
    test_random(1250, 1'b1);
    test_wait_empty();
    test_random(400, 1'b0);
    drain();
    if (errors == 0 && phi_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ tvd_flux_limiter_unit.f @@
rtl/core/tfl_pkg.sv
rtl/core/tfl_prep.sv
rtl/core/tfl_div.sv
rtl/core/tfl_post.sv
rtl/core/tvd_flux_limiter_unit.sv
sim/tvd_flux_limiter_unit_test.sv
